// File: hw/rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types, event codes and status constants of the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   // width of the running tick counter, wraps at this many bits
   localparam int TIME_BITS = 32;

   localparam int LEN_BITS = 28;

   // event codes carried in event_kind
   localparam logic [3:0] KIND_NOTE_ON     = 4'd0;
   localparam logic [3:0] KIND_NOTE_OFF    = 4'd1;
   localparam logic [3:0] KIND_PROGRAM     = 4'd2;
   localparam logic [3:0] KIND_CHANNEL     = 4'd3;
   localparam logic [3:0] KIND_META        = 4'd4;
   localparam logic [3:0] KIND_SYSEX_DONE  = 4'd5;
   localparam logic [3:0] KIND_ARBITRARY   = 4'd6;
   localparam logic [3:0] KIND_SYSEX_ERR   = 4'd7;
   localparam logic [3:0] KIND_RUNNING_ERR = 4'd8;
   localparam logic [3:0] KIND_UNEXPECTED  = 4'd9;

   // status bytes with special meaning
   localparam logic [7:0] STATUS_META      = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;

   // high nibbles of channel status bytes
   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_start;
   } req_type;

   typedef struct packed {
      logic [3:0]          event_kind;
      logic [3:0]          channel;
      logic [7:0]          status_byte;
      logic [7:0]          first_data;
      logic [7:0]          second_data;
      logic [31:0]         event_time;
      logic [7:0]          meta_type;
      logic [LEN_BITS-1:0] payload_length;
      logic [7:0]          meta_fourth_byte;
   } rsp_type;

   // data bytes that follow a status byte, indexed by bits 6:4 of the status
   function automatic logic [1:0] data_count(input logic [2:0] nib);
      logic [1:0] cnt;
      case (nib)
         3'd4, 3'd5: cnt = 2'd1;
         3'd7:       cnt = 2'd0;
         default:    cnt = 2'd2;
      endcase
      return cnt;
   endfunction

endpackage

// File: hw/rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Byte-serial parser for the body of a standard MIDI file track chunk.
// ----------------------------------------------------------------------------
// Takes one track body byte per item and sustains one item per clock cycle while the result side does not stall.
// An accepted byte sits in the input register while the parse step (delta time
// decode, running status, data byte counts, block skipping) runs in plain
// logic; a completed event lands in the result register on the edge at which
// the byte leaves the input register.
// The input side keeps taking bytes while a result waits, as long as the
// result register is free or is being drained in the same cycle.
// Set track_start on the first body byte of every track: it clears tick time,
// running status and the sysex continuation mark and, with reset, is the only
// way out of the fatal error state (missing sysex continuation or running status
// with no prior status). Bytes that yield no event produce no result item.
module midi_track_event_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mtep_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mtep_pkg::rsp_type rsp_item
);

   logic              in_valid_ff;
   mtep_pkg::req_type in_item_ff;
   logic              rsp_valid_ff;
   mtep_pkg::rsp_type rsp_item_ff;
   logic              advance;
   logic              step_en;
   logic              emit;
   mtep_pkg::rsp_type emit_item;

   // result register is free or drains this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   // hold the byte only when it has nowhere to go
   assign req_stall = in_valid_ff && !advance;
   assign step_en   = in_valid_ff && advance;

   mtep_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .step_item (in_item_ff),
      .emit      (emit),
      .emit_item (emit_item)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_item_ff <= emit_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with the result side free");

   a_step_keeps_result: assert property (@(posedge clock) disable iff (reset)
      (step_en && emit) |=> rsp_valid)
      else $error("event lost on its way to the result register");

   a_pending_byte_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("waiting byte dropped or changed");
`endif

endmodule

// File: hw/rtl/mtep_core.sv
// ----------------------------------------------------------------------------
// mtep_core
// Parse state of the track event parser and the per-byte step logic.
// ----------------------------------------------------------------------------
module mtep_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  mtep_pkg::req_type step_item,
   output logic              emit,
   output mtep_pkg::rsp_type emit_item
);

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_EVENT,
      PH_DATA1,
      PH_DATA2,
      PH_MTYPE,
      PH_LEN,
      PH_BODY,
      PH_DEAD
   } phase_type;

   localparam int LB = mtep_pkg::LEN_BITS;
   localparam int TB = mtep_pkg::TIME_BITS;

   phase_type         phase_ff, phase_in, e_phase;
   logic [TB-1:0]     tick_ff, tick_in, e_tick;
   logic [31:0]       vlq_ff, vlq_in, e_vlq;
   logic [7:0]        rs_ff, rs_in, e_rs;
   logic              sp_ff, sp_in, e_sp;
   logic [7:0]        first_ff, first_in, e_first;
   logic [7:0]        mtype_ff, mtype_in, e_mtype;
   logic [LB-1:0]     rem_ff, rem_in, e_rem;
   logic [LB-1:0]     blen_ff, blen_in, e_blen;
   logic [7:0]        last_ff, last_in, e_last;
   logic [7:0]        fourth_ff, fourth_in, e_fourth;

   logic [7:0]        b;
   logic [31:0]       acc;
   logic [63:0]       tick_ext;
   logic              do_channel, do_finish, running, hit;
   logic [7:0]        ch_d1, ch_d2;
   logic [1:0]        need;
   logic [3:0]        hi;
   logic [LB-1:0]     rem_dec;
   mtep_pkg::rsp_type item;

   // track start clears the parse state before the byte is taken
   assign e_phase  = step_item.track_start ? PH_DELTA : phase_ff;
   assign e_tick   = step_item.track_start ? '0 : tick_ff;
   assign e_vlq    = step_item.track_start ? '0 : vlq_ff;
   assign e_rs     = step_item.track_start ? '0 : rs_ff;
   assign e_sp     = step_item.track_start ? 1'b0 : sp_ff;
   assign e_first  = step_item.track_start ? '0 : first_ff;
   assign e_mtype  = step_item.track_start ? '0 : mtype_ff;
   assign e_rem    = step_item.track_start ? '0 : rem_ff;
   assign e_blen   = step_item.track_start ? '0 : blen_ff;
   assign e_last   = step_item.track_start ? '0 : last_ff;
   assign e_fourth = step_item.track_start ? '0 : fourth_ff;

   assign b        = step_item.data_byte;
   assign acc      = {e_vlq[24:0], b[6:0]};
   assign tick_ext = 64'(e_tick);
   assign rem_dec  = e_rem - LB'(1);

   always_comb begin
      phase_in   = e_phase;
      tick_in    = e_tick;
      vlq_in     = e_vlq;
      rs_in      = e_rs;
      sp_in      = e_sp;
      first_in   = e_first;
      mtype_in   = e_mtype;
      rem_in     = e_rem;
      blen_in    = e_blen;
      last_in    = e_last;
      fourth_in  = e_fourth;
      do_channel = 1'b0;
      do_finish  = 1'b0;
      running    = 1'b0;
      ch_d1      = '0;
      ch_d2      = '0;
      need       = '0;
      hi         = '0;
      hit        = 1'b0;
      item       = '0;
      item.event_time = tick_ext[31:0];

      unique case (e_phase)
         PH_DELTA: begin
            if (!b[7]) begin
               tick_in  = e_tick + TB'(acc);
               vlq_in   = '0;
               phase_in = PH_EVENT;
            end else begin
               vlq_in = acc;
            end
         end
         PH_EVENT: begin
            if (e_sp && b != mtep_pkg::STATUS_SYSEX_END) begin
               phase_in         = PH_DEAD;
               hit              = 1'b1;
               item.event_kind  = mtep_pkg::KIND_SYSEX_ERR;
               item.status_byte = e_rs;
               item.first_data  = b;
            end else if (!b[7] && e_rs == 8'h00) begin
               phase_in         = PH_DEAD;
               hit              = 1'b1;
               item.event_kind  = mtep_pkg::KIND_RUNNING_ERR;
               item.first_data  = b;
            end else begin
               running = !b[7];
               if (b[7]) begin
                  rs_in = b;
               end
               need = rs_in[7] ? mtep_pkg::data_count(rs_in[6:4]) : 2'd0;
               if (need != 2'd0) begin
                  if (!running) begin
                     phase_in = PH_DATA1;
                  end else begin
                     first_in = b;
                     if (need == 2'd1) begin
                        do_channel = 1'b1;
                        ch_d1      = b;
                     end else begin
                        phase_in = PH_DATA2;
                     end
                  end
               end else if (b == mtep_pkg::STATUS_META || b == mtep_pkg::STATUS_SYSEX
                            || b == mtep_pkg::STATUS_SYSEX_END) begin
                  mtype_in  = '0;
                  fourth_in = '0;
                  last_in   = b;
                  vlq_in    = '0;
                  phase_in  = (b == mtep_pkg::STATUS_META) ? PH_MTYPE : PH_LEN;
               end else begin
                  phase_in         = PH_DELTA;
                  vlq_in           = '0;
                  hit              = 1'b1;
                  item.event_kind  = mtep_pkg::KIND_UNEXPECTED;
                  item.status_byte = rs_in;
                  item.first_data  = b;
               end
            end
         end
         PH_DATA1: begin
            first_in = b;
            if (mtep_pkg::data_count(e_rs[6:4]) == 2'd1) begin
               do_channel = 1'b1;
               ch_d1      = b;
            end else begin
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            do_channel = 1'b1;
            ch_d1      = e_first;
            ch_d2      = b;
         end
         PH_MTYPE: begin
            mtype_in = b;
            vlq_in   = '0;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            if (!b[7]) begin
               blen_in = acc[LB-1:0];
               rem_in  = acc[LB-1:0];
               vlq_in  = '0;
               if (acc[LB-1:0] == '0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = PH_BODY;
               end
            end else begin
               vlq_in = acc;
            end
         end
         PH_BODY: begin
            if (e_blen - e_rem == LB'(3)) begin
               fourth_in = b;
            end
            last_in = b;
            rem_in  = rem_dec;
            if (rem_dec == '0) begin
               do_finish = 1'b1;
            end
         end
         PH_DEAD: begin
         end
         default: begin
            phase_in = PH_DELTA;
            vlq_in   = '0;
         end
      endcase

      // channel message complete
      if (do_channel) begin
         hi       = rs_in[7:4];
         phase_in = PH_DELTA;
         vlq_in   = '0;
         hit      = 1'b1;
         if (hi == mtep_pkg::NIB_NOTE_ON && ch_d2 != 8'h00) begin
            item.event_kind = mtep_pkg::KIND_NOTE_ON;
         end else if (hi == mtep_pkg::NIB_NOTE_OFF || hi == mtep_pkg::NIB_NOTE_ON) begin
            item.event_kind = mtep_pkg::KIND_NOTE_OFF;
         end else if (hi == mtep_pkg::NIB_PROGRAM) begin
            item.event_kind = mtep_pkg::KIND_PROGRAM;
         end else begin
            item.event_kind = mtep_pkg::KIND_CHANNEL;
         end
         item.channel     = rs_in[3:0];
         item.status_byte = rs_in;
         item.first_data  = ch_d1;
         item.second_data = ch_d2;
      end

      // meta, sysex or escape block complete
      if (do_finish) begin
         phase_in = PH_DELTA;
         vlq_in   = '0;
         item.payload_length = blen_in;
         if (e_rs == mtep_pkg::STATUS_META) begin
            hit                   = 1'b1;
            item.event_kind       = mtep_pkg::KIND_META;
            item.status_byte      = mtep_pkg::STATUS_META;
            item.meta_type        = e_mtype;
            item.meta_fourth_byte = fourth_in;
         end else if (e_rs == mtep_pkg::STATUS_SYSEX) begin
            if (last_in == mtep_pkg::STATUS_SYSEX_END) begin
               hit              = 1'b1;
               item.event_kind  = mtep_pkg::KIND_SYSEX_DONE;
               item.status_byte = mtep_pkg::STATUS_SYSEX;
            end else begin
               sp_in = 1'b1;
            end
         end else if (!e_sp) begin
            hit              = 1'b1;
            item.event_kind  = mtep_pkg::KIND_ARBITRARY;
            item.status_byte = mtep_pkg::STATUS_SYSEX_END;
         end else if (last_in == mtep_pkg::STATUS_SYSEX_END) begin
            sp_in            = 1'b0;
            hit              = 1'b1;
            item.event_kind  = mtep_pkg::KIND_SYSEX_DONE;
            item.status_byte = mtep_pkg::STATUS_SYSEX_END;
         end
      end
   end

   assign emit      = step_en && hit;
   assign emit_item = item;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         tick_ff   <= '0;
         vlq_ff    <= '0;
         rs_ff     <= '0;
         sp_ff     <= 1'b0;
         first_ff  <= '0;
         mtype_ff  <= '0;
         rem_ff    <= '0;
         blen_ff   <= '0;
         last_ff   <= '0;
         fourth_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         vlq_ff    <= vlq_in;
         rs_ff     <= rs_in;
         sp_ff     <= sp_in;
         first_ff  <= first_in;
         mtype_ff  <= mtype_in;
         rem_ff    <= rem_in;
         blen_ff   <= blen_in;
         last_ff   <= last_in;
         fourth_ff <= fourth_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_dead_holds: assert property (@(posedge clock) disable iff (reset)
      (step_en && phase_ff == PH_DEAD && !step_item.track_start) |=> phase_ff == PH_DEAD)
      else $error("dead phase left without track start");

   a_fatal_goes_dead: assert property (@(posedge clock) disable iff (reset)
      (emit && (emit_item.event_kind == mtep_pkg::KIND_SYSEX_ERR
                || emit_item.event_kind == mtep_pkg::KIND_RUNNING_ERR))
      |=> phase_ff == PH_DEAD)
      else $error("fatal error did not stop parsing");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rs_ff == 8'h00 || rs_ff[7])
      else $error("running status holds a data byte");
`endif

endmodule

// File: test/midi_track_event_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_checker
// Watches both item channels of the track event parser. It decodes every
// accepted byte on its own copy of the parse state, queues the event that
// the byte completes, and compares result items with that queue in order.
// ----------------------------------------------------------------------------
module midi_track_event_parser_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  mtep_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  mtep_pkg::rsp_type rsp_item,
   output int                fail_count,
   output int                awaiting,
   output int                events_checked
);

   typedef enum logic [2:0] {
      STEP_DELTA,
      STEP_EVENT,
      STEP_DATA1,
      STEP_DATA2,
      STEP_META_TYPE,
      STEP_LENGTH,
      STEP_SKIP,
      STEP_HALTED
   } parse_step_type;

   // data bytes per channel status, indexed by status bits 6:4
   localparam logic [1:0] DATA_BYTES [8] = '{2'd2, 2'd2, 2'd2, 2'd2,
                                             2'd1, 2'd1, 2'd2, 2'd0};

   parse_step_type                 parse_step;
   logic [mtep_pkg::TIME_BITS-1:0] tick_count;
   logic [31:0]                    number_acc;
   logic [7:0]                     held_status;
   logic                           sysex_open;
   logic [7:0]                     data_hold;
   logic [7:0]                     meta_hold;
   logic [mtep_pkg::LEN_BITS-1:0]  left_to_skip;
   logic [mtep_pkg::LEN_BITS-1:0]  block_len;
   logic [7:0]                     block_last;
   logic [7:0]                     fourth_hold;

   mtep_pkg::rsp_type event_q[$];
   mtep_pkg::rsp_type predicted;
   mtep_pkg::rsp_type want;

   function automatic void clear_parser();
      parse_step   = STEP_DELTA;
      tick_count   = '0;
      number_acc   = '0;
      held_status  = '0;
      sysex_open   = 1'b0;
      data_hold    = '0;
      meta_hold    = '0;
      left_to_skip = '0;
      block_len    = '0;
      block_last   = '0;
      fourth_hold  = '0;
   endfunction

   function automatic mtep_pkg::rsp_type pack_event(
         input logic [3:0] kind, chan,
         input logic [7:0] status, d1, d2, mtype,
         input logic [mtep_pkg::LEN_BITS-1:0] len,
         input logic [7:0] fourth);
      mtep_pkg::rsp_type ev;
      ev.event_kind       = kind;
      ev.channel          = chan;
      ev.status_byte      = status;
      ev.first_data       = d1;
      ev.second_data      = d2;
      ev.event_time       = 32'(tick_count);
      ev.meta_type        = mtype;
      ev.payload_length   = len;
      ev.meta_fourth_byte = fourth;
      return ev;
   endfunction

   function automatic mtep_pkg::rsp_type channel_event(input logic [7:0] d1, d2);
      logic [3:0] kind;
      if (held_status[7:4] == mtep_pkg::NIB_NOTE_ON && d2 != 8'd0)
         kind = mtep_pkg::KIND_NOTE_ON;
      else if (held_status[7:4] == mtep_pkg::NIB_NOTE_ON
               || held_status[7:4] == mtep_pkg::NIB_NOTE_OFF)
         kind = mtep_pkg::KIND_NOTE_OFF;
      else if (held_status[7:4] == mtep_pkg::NIB_PROGRAM)
         kind = mtep_pkg::KIND_PROGRAM;
      else
         kind = mtep_pkg::KIND_CHANNEL;
      parse_step = STEP_DELTA;
      number_acc = '0;
      return pack_event(kind, held_status[3:0], held_status, d1, d2, 8'd0, '0, 8'd0);
   endfunction

   // end of a skipped block; an unterminated sysex yields nothing
   function automatic bit close_block(output mtep_pkg::rsp_type ev);
      parse_step = STEP_DELTA;
      number_acc = '0;
      if (held_status == mtep_pkg::STATUS_META) begin
         ev = pack_event(mtep_pkg::KIND_META, 4'd0, mtep_pkg::STATUS_META, 8'd0, 8'd0,
                         meta_hold, block_len, fourth_hold);
         return 1'b1;
      end
      if (held_status == mtep_pkg::STATUS_SYSEX) begin
         if (block_last == mtep_pkg::STATUS_SYSEX_END) begin
            ev = pack_event(mtep_pkg::KIND_SYSEX_DONE, 4'd0, mtep_pkg::STATUS_SYSEX,
                            8'd0, 8'd0, 8'd0, block_len, 8'd0);
            return 1'b1;
         end
         sysex_open = 1'b1;
         return 1'b0;
      end
      if (!sysex_open) begin
         ev = pack_event(mtep_pkg::KIND_ARBITRARY, 4'd0, mtep_pkg::STATUS_SYSEX_END,
                         8'd0, 8'd0, 8'd0, block_len, 8'd0);
         return 1'b1;
      end
      if (block_last == mtep_pkg::STATUS_SYSEX_END) begin
         sysex_open = 1'b0;
         ev = pack_event(mtep_pkg::KIND_SYSEX_DONE, 4'd0, mtep_pkg::STATUS_SYSEX_END,
                         8'd0, 8'd0, 8'd0, block_len, 8'd0);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit take_event_byte(input logic [7:0] b,
                                          output mtep_pkg::rsp_type ev);
      logic [1:0] need;
      bit         running;
      if (sysex_open && b != mtep_pkg::STATUS_SYSEX_END) begin
         parse_step = STEP_HALTED;
         ev = pack_event(mtep_pkg::KIND_SYSEX_ERR, 4'd0, held_status, b, 8'd0, 8'd0,
                         '0, 8'd0);
         return 1'b1;
      end
      if (!b[7]) begin
         if (held_status == 8'd0) begin
            parse_step = STEP_HALTED;
            ev = pack_event(mtep_pkg::KIND_RUNNING_ERR, 4'd0, 8'd0, b, 8'd0, 8'd0,
                            '0, 8'd0);
            return 1'b1;
         end
         running = 1'b1;
      end else begin
         held_status = b;
         running = 1'b0;
      end
      need = held_status[7] ? DATA_BYTES[held_status[6:4]] : 2'd0;
      if (need != 2'd0) begin
         if (!running) begin
            parse_step = STEP_DATA1;
            return 1'b0;
         end
         data_hold = b;
         if (need == 2'd1) begin
            ev = channel_event(b, 8'd0);
            return 1'b1;
         end
         parse_step = STEP_DATA2;
         return 1'b0;
      end
      if (b == mtep_pkg::STATUS_META || b == mtep_pkg::STATUS_SYSEX
          || b == mtep_pkg::STATUS_SYSEX_END) begin
         meta_hold   = '0;
         fourth_hold = '0;
         block_last  = b;
         number_acc  = '0;
         if (b == mtep_pkg::STATUS_META)
            parse_step = STEP_META_TYPE;
         else
            parse_step = STEP_LENGTH;
         return 1'b0;
      end
      parse_step = STEP_DELTA;
      number_acc = '0;
      ev = pack_event(mtep_pkg::KIND_UNEXPECTED, 4'd0, held_status, b, 8'd0, 8'd0,
                      '0, 8'd0);
      return 1'b1;
   endfunction

   function automatic bit parse_byte(input mtep_pkg::req_type it,
                                     output mtep_pkg::rsp_type ev);
      logic [7:0] b;
      b = it.data_byte;
      if (it.track_start)
         clear_parser();
      case (parse_step)
         STEP_DELTA: begin
            number_acc = {number_acc[24:0], b[6:0]};
            if (!b[7]) begin
               tick_count = tick_count + mtep_pkg::TIME_BITS'(number_acc);
               number_acc = '0;
               parse_step = STEP_EVENT;
            end
         end
         STEP_EVENT:
            return take_event_byte(b, ev);
         STEP_DATA1: begin
            data_hold = b;
            if (DATA_BYTES[held_status[6:4]] == 2'd1) begin
               ev = channel_event(b, 8'd0);
               return 1'b1;
            end
            parse_step = STEP_DATA2;
         end
         STEP_DATA2: begin
            ev = channel_event(data_hold, b);
            return 1'b1;
         end
         STEP_META_TYPE: begin
            meta_hold  = b;
            number_acc = '0;
            parse_step = STEP_LENGTH;
         end
         STEP_LENGTH: begin
            number_acc = {number_acc[24:0], b[6:0]};
            if (!b[7]) begin
               block_len    = number_acc[mtep_pkg::LEN_BITS-1:0];
               left_to_skip = block_len;
               number_acc   = '0;
               if (block_len == '0)
                  return close_block(ev);
               parse_step = STEP_SKIP;
            end
         end
         STEP_SKIP: begin
            if (block_len - left_to_skip == mtep_pkg::LEN_BITS'(3))
               fourth_hold = b;
            block_last   = b;
            left_to_skip = left_to_skip - mtep_pkg::LEN_BITS'(1);
            if (left_to_skip == '0)
               return close_block(ev);
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v, got_v);
      if (want_v !== got_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         event_q.delete();
         fail_count = 0;
         events_checked = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (parse_byte(req_item, predicted))
               event_q.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (event_q.size() == 0) begin
               $error("result item with no event pending, event_kind 0x%0h",
                      rsp_item.event_kind);
               fail_count++;
            end else begin
               want = event_q.pop_front();
               events_checked++;
               check_field("event_kind", 32'(want.event_kind),
                           32'(rsp_item.event_kind));
               check_field("channel", 32'(want.channel), 32'(rsp_item.channel));
               check_field("status_byte", 32'(want.status_byte),
                           32'(rsp_item.status_byte));
               check_field("first_data", 32'(want.first_data),
                           32'(rsp_item.first_data));
               check_field("second_data", 32'(want.second_data),
                           32'(rsp_item.second_data));
               check_field("event_time", want.event_time, rsp_item.event_time);
               check_field("meta_type", 32'(want.meta_type), 32'(rsp_item.meta_type));
               check_field("payload_length", 32'(want.payload_length),
                           32'(rsp_item.payload_length));
               check_field("meta_fourth_byte", 32'(want.meta_fourth_byte),
                           32'(rsp_item.meta_fourth_byte));
            end
         end
      end
      awaiting = event_q.size();
   end

endmodule

// File: test/midi_track_event_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_tb
// Feeds the track event parser a byte stream of short tracks: a fixed opening
// sequence, then random tracks of well-formed events with random content,
// mixed with malformed and fatal sequences. The sender works in bursts and
// the receiver stalls on its own pattern; a side checker predicts and
// compares every event.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;

   localparam int PERIOD       = 10;
   localparam int RESET_CYCLES = 10;
   localparam int STREAM_BYTES = 1850;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // channel pressure nibble, a one data byte message like program change
   localparam logic [3:0] NIB_PRESSURE = 4'hD;

   // opening track, bit 8 marks the track start
   localparam logic [8:0] OPENING [29] = '{
      9'h100, 9'h090, 9'h03C, 9'h07F,                         // note on, ch 0
      9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h03C, 9'h000,         // max delta, running, vel 0
      9'h000, 9'h0CF, 9'h07F,                                 // program, ch 15
      9'h000, 9'h0FF, 9'h058, 9'h004,
      9'h001, 9'h002, 9'h003, 9'h0FF,                         // meta with fourth byte
      9'h000, 9'h0F0, 9'h000,                                 // empty sysex, left open
      9'h000, 9'h0F7, 9'h000,                                 // empty continuation closes it
      9'h000, 9'h0F9                                          // unexpected status
   };

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_HOLD
   } rx_mode_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mtep_pkg::req_type req_item  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mtep_pkg::rsp_type rsp_item;

   int fail_count;
   int awaiting;
   int events_checked;
   int cycles = 0;

   // byte stream and generator state
   mtep_pkg::req_type byte_q[$];
   bit                start_flag   = 1'b0;
   logic [7:0]        track_status = '0;
   bit                track_halted = 1'b0;
   int                tracks_made  = 0;

   // receiver stall pattern state
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          rx_hold = 0;

   midi_track_event_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   midi_track_event_parser_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .fail_count     (fail_count),
      .awaiting       (awaiting),
      .events_checked (events_checked)
   );

   always #(PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("midi_track_event_parser_tb: done, errors");
         $finish;
      end
   end

   // receiver: open, coin-flip or long hold stretches of random length
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(20, 150);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN: rsp_stall <= 1'b0;
         RX_COIN: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            // toggle stall after a hold of random length
            if (rx_hold == 0) begin
               rx_hold = $urandom_range(1, 12);
               rsp_stall <= ~rsp_stall;
            end else begin
               rx_hold--;
            end
         end
      endcase
   end

   // append one body byte, flagging the first byte of a track
   task automatic put_byte(input logic [7:0] b);
      mtep_pkg::req_type it;
      it.data_byte   = b;
      it.track_start = start_flag;
      start_flag     = 1'b0;
      byte_q.push_back(it);
   endtask

   // variable-length number, most significant group first
   task automatic put_number(input logic [34:0] v, input int groups);
      for (int i = groups - 1; i >= 0; i--)
         put_byte({i != 0, v[7*i +: 7]});
   endtask

   function automatic int min_groups(input logic [34:0] v);
      int n;
      n = 1;
      while (n < 5 && (v >> (7 * n)) != 0)
         n++;
      return n;
   endfunction

   function automatic int block_size();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(13, 60);
      return $urandom_range(0, 8);
   endfunction

   task automatic put_delta();
      int         pick;
      logic [34:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         put_number(35'($urandom_range(0, 127)), 1);
      end else if (pick < 80) begin
         v = 35'($urandom_range(128, 2097151));
         put_number(v, min_groups(v));
      end else if (pick < 90) begin
         // four-byte deltas up to the largest legal value, wraps tick time fast
         if ($urandom_range(0, 3) == 0)
            v = 35'h0FFFFFFF;
         else
            v = 35'($urandom_range(0, 32'h0FFFFFFF));
         put_number(v, 4);
      end else if (pick < 95) begin
         // small value padded with leading empty groups
         put_number(35'($urandom_range(0, 127)), $urandom_range(2, 4));
      end else begin
         // overlong delta, shifted in modulo 2^32
         repeat ($urandom_range(4, 6)) put_byte(8'($urandom_range(128, 255)));
         put_byte(8'($urandom_range(0, 127)));
      end
   endtask

   task automatic put_length(input int len);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 8)
         put_number(35'(len), min_groups(35'(len)));
      else if (pick == 8)
         put_number(35'(len), 4);
      else
         // five groups, the bits above 28 must be dropped
         put_number({7'($urandom_range(0, 127)), 28'(len)}, 5);
   endtask

   // meta, sysex or continuation block with a chosen last payload byte
   task automatic put_block(input logic [7:0] lead, input int len, input logic [7:0] tail);
      put_delta();
      put_byte(lead);
      if (lead == mtep_pkg::STATUS_META)
         put_byte(8'($urandom));
      put_length(len);
      for (int i = 0; i < len; i++)
         put_byte((i == len - 1) ? tail : 8'($urandom));
      track_status = lead;
   endtask

   task automatic put_channel();
      logic [7:0] d1;
      logic [7:0] d2;
      bit         running;
      put_delta();
      running = track_status[7] && track_status < mtep_pkg::STATUS_SYSEX
                && $urandom_range(0, 2) == 0;
      if (!running) begin
         track_status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
         put_byte(track_status);
      end
      // after an explicit status the first data byte may carry the top bit
      if (!running && $urandom_range(0, 7) == 0)
         d1 = 8'($urandom);
      else
         d1 = 8'($urandom_range(0, 127));
      if ($urandom_range(0, 4) == 0)
         d2 = 8'd0;
      else if ($urandom_range(0, 7) == 0)
         d2 = 8'($urandom);
      else
         d2 = 8'($urandom_range(0, 127));
      put_byte(d1);
      if (track_status[7:4] != mtep_pkg::NIB_PROGRAM && track_status[7:4] != NIB_PRESSURE)
         put_byte(d2);
   endtask

   task automatic put_sysex();
      int         len;
      logic [7:0] tail;
      logic [7:0] b;
      len = block_size();
      if ($urandom_range(0, 9) < 6)
         tail = mtep_pkg::STATUS_SYSEX_END;
      else
         tail = 8'($urandom_range(0, 127));
      put_block(mtep_pkg::STATUS_SYSEX, len, tail);
      if (len != 0 && tail == mtep_pkg::STATUS_SYSEX_END)
         return;
      if ($urandom_range(0, 9) == 0) begin
         // continuation missing, the track is dead from here
         put_delta();
         b = 8'($urandom);
         if (b == mtep_pkg::STATUS_SYSEX_END)
            b = 8'd0;
         put_byte(b);
         track_halted = 1'b1;
         return;
      end
      repeat ($urandom_range(0, 2))
         put_block(mtep_pkg::STATUS_SYSEX_END, $urandom_range(1, 6),
                   8'($urandom_range(0, 127)));
      put_block(mtep_pkg::STATUS_SYSEX_END, $urandom_range(0, 6), mtep_pkg::STATUS_SYSEX_END);
   endtask

   task automatic put_unexpected();
      logic [7:0] b;
      put_delta();
      if (track_status >= mtep_pkg::STATUS_SYSEX && $urandom_range(0, 1) == 1) begin
         // data byte under a held system status
         b = 8'($urandom_range(0, 127));
      end else begin
         do
            b = 8'($urandom_range(mtep_pkg::STATUS_SYSEX + 1, mtep_pkg::STATUS_META - 1));
         while (b == mtep_pkg::STATUS_SYSEX_END);
         track_status = b;
      end
      put_byte(b);
   endtask

   task automatic put_track();
      int events;
      int pick;
      start_flag   = 1'b1;
      track_status = '0;
      track_halted = 1'b0;
      tracks_made++;
      if ($urandom_range(0, 11) == 0) begin
         // data byte with no status yet, rest of the track is ignored
         put_delta();
         put_byte(8'($urandom_range(0, 127)));
         repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
         return;
      end
      events = $urandom_range(2, 30);
      while (events > 0 && !track_halted) begin
         pick = $urandom_range(0, 99);
         if (pick < 52)
            put_channel();
         else if (pick < 66)
            put_block(mtep_pkg::STATUS_META, block_size(), 8'($urandom));
         else if (pick < 76)
            put_sysex();
         else if (pick < 82)
            put_block(mtep_pkg::STATUS_SYSEX_END, block_size(), 8'($urandom));
         else if (pick < 92)
            put_unexpected();
         else if (pick < 95)
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
         else
            put_channel();
         events--;
      end
   endtask

   initial begin
      mtep_pkg::req_type it;
      int                total;
      int                burst;
      int                gap;

      // build the whole stream up front
      foreach (OPENING[i]) begin
         it.data_byte   = OPENING[i][7:0];
         it.track_start = OPENING[i][8];
         byte_q.push_back(it);
      end
      while (byte_q.size() < STREAM_BYTES)
         put_track();
      total = byte_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bursts of back-to-back items, then a random gap or none at all
      while (byte_q.size() != 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && byte_q.size() != 0) begin
            @(negedge clock);
            req_valid <= 1'b1;
            req_item  <= byte_q.pop_front();
            do @(posedge clock); while (req_stall);
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then stay idle to catch any stray result
      do @(negedge clock); while (awaiting != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d track body bytes in %0d tracks, %0d events compared",
               total, tracks_made + 1, events_checked);
      $display("sender bursts and receiver stalls mixed over %0d cycles", cycles);
      if (fail_count == 0 && awaiting == 0)
         $display("midi_track_event_parser_tb: done, clean");
      else
         $display("midi_track_event_parser_tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_core.sv
hw/rtl/midi_track_event_parser.sv
test/midi_track_event_parser_checker.sv
test/midi_track_event_parser_tb.sv
